[hdl/bdsa_pkg.sv]
// Shared types, codes and constants of the bounded difference sequence aligner.
// Used by the controller, the datapath and the top level; depends on nothing.
package bdsa_pkg;

  localparam int MAX_SEQ_LEN_DEF = 256;
  localparam logic [4:0] ANCHOR_RESET = 5'd5;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam logic CFG_DIFF_BUDGET = 1'b0;
  localparam logic CFG_ANCHOR_LEN  = 1'b1;

  localparam logic [9:0] CL_MAX = 10'd1023;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RD_IJ,
    OP_STEP,
    OP_MISS,
    OP_PREV,
    OP_Z0,
    OP_ZINC,
    OP_ENG_MM,
    OP_ENG_HAS,
    OP_ENG_HAR,
    OP_ENG_HBS,
    OP_ENG_HBR,
    OP_ENG_T1,
    OP_ENG_T2A,
    OP_ENG_T2B,
    OP_ENG_RD,
    OP_ENG_NEXT,
    OP_JMP_MM,
    OP_JMP_HA,
    OP_JMP_HB,
    OP_USED_INC,
    OP_FAIL,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic loop_go;
    logic eq;
    logic guard;
    logic z_lt_rem;
    logic eng_stop;
    logic eng_eq;
    logic c_eq_a;
    logic c_eq_b;
    logic out_busy;
  } sts_t;

endpackage

[hdl/bounded_difference_sequence_aligner_top.sv]
// Top level of the bounded difference sequence aligner: a load item appends one base to
// its store; a start item walks both stores, reading each compared base pair through the
// registered read ports of the two sequence memories, as each search compare does too.
// The result is registered after the walk ends and waits in an output register.
// Synchronous active-low reset resets lengths, configuration, the controller and out_tvalid.
module bounded_difference_sequence_aligner_top #(
  parameter int MAX_SEQ_LEN = bdsa_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // base, previous_base, prior_consistent_len, prior_diff_count, prior_ok
  input  logic [23:0] in_tdata,
  // mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // consistent_len, diff_count, overlap_ok
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import bdsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdsa_dp #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hdl/bdsa_ctrl.sv]
// Controller state machine of the aligner: sequences loads, the walk, the searches
// and the result. Depends on bdsa_pkg; drives bdsa_dp through cmd_t and reads sts_t.
module bdsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [1:0]    in_mode,
  output logic          in_tready,
  input  bdsa_pkg::sts_t sts,
  output bdsa_pkg::cmd_t cmd
);
  import bdsa_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_LOOP  = 13'h0002,
    S_CMP   = 13'h0004,
    S_PREV  = 13'h0008,
    S_GUARD = 13'h0010,
    S_MM    = 13'h0020,
    S_HA    = 13'h0040,
    S_ENG   = 13'h0080,
    S_ENGC  = 13'h0100,
    S_T2    = 13'h0200,
    S_DONE  = 13'h0400,
    S_SPARE = 13'h0800,
    S_SPAR2 = 13'h1000
  } state_t;

  typedef enum logic [6:0] {
    PH_MM  = 7'h01,
    PH_HAS = 7'h02,
    PH_HAR = 7'h04,
    PH_HBS = 7'h08,
    PH_HBR = 7'h10,
    PH_TA  = 7'h20,
    PH_TF  = 7'h40
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   eng_end;
  logic   eng_pass;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NONE;
    eng_end   = 1'b0;
    eng_pass  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_mode == MODE_LOAD_A || in_mode == MODE_LOAD_B) begin
            cmd.op = OP_LOAD;
          end else if (in_mode == MODE_START) begin
            cmd.op    = OP_START;
            state_nxt = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (sts.loop_go) begin
          cmd.op    = OP_RD_IJ;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (sts.eq) begin
          cmd.op    = OP_STEP;
          state_nxt = S_LOOP;
        end else begin
          cmd.op    = OP_MISS;
          state_nxt = S_PREV;
        end
      end
      S_PREV: begin
        cmd.op    = OP_PREV;
        state_nxt = S_GUARD;
      end
      S_GUARD: begin
        if (sts.guard) begin
          cmd.op    = OP_Z0;
          state_nxt = S_MM;
        end else begin
          cmd.op    = OP_ENG_T1;
          phase_nxt = PH_TA;
          state_nxt = S_ENG;
        end
      end
      S_MM: begin
        if (sts.z_lt_rem) begin
          cmd.op    = OP_ENG_MM;
          phase_nxt = PH_MM;
          state_nxt = S_ENG;
        end else begin
          cmd.op    = OP_Z0;
          state_nxt = S_HA;
        end
      end
      S_HA: begin
        if (sts.z_lt_rem) begin
          cmd.op    = OP_ENG_HAS;
          phase_nxt = PH_HAS;
          state_nxt = S_ENG;
        end else begin
          cmd.op    = OP_FAIL;
          state_nxt = S_DONE;
        end
      end
      S_ENG: begin
        if (sts.eng_stop) begin
          eng_end  = 1'b1;
          eng_pass = 1'b1;
        end else begin
          cmd.op    = OP_ENG_RD;
          state_nxt = S_ENGC;
        end
      end
      S_ENGC: begin
        if (sts.eng_eq) begin
          cmd.op    = OP_ENG_NEXT;
          state_nxt = S_ENG;
        end else begin
          eng_end = 1'b1;
        end
      end
      S_T2: begin
        if (sts.c_eq_a) begin
          cmd.op    = OP_ENG_T2A;
          phase_nxt = PH_TF;
          state_nxt = S_ENG;
        end else if (sts.c_eq_b) begin
          cmd.op    = OP_ENG_T2B;
          phase_nxt = PH_TF;
          state_nxt = S_ENG;
        end else begin
          cmd.op    = OP_FAIL;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (eng_end) begin
      unique case (phase_r)
        PH_MM: begin
          cmd.op    = eng_pass ? OP_JMP_MM : OP_ZINC;
          state_nxt = eng_pass ? S_LOOP : S_MM;
        end
        PH_HAS: begin
          cmd.op    = eng_pass ? OP_ENG_HAR : OP_ENG_HBS;
          phase_nxt = eng_pass ? PH_HAR : PH_HBS;
          state_nxt = S_ENG;
        end
        PH_HAR: begin
          if (eng_pass) begin
            cmd.op    = OP_JMP_HA;
            state_nxt = S_LOOP;
          end else begin
            cmd.op    = OP_ENG_HBS;
            phase_nxt = PH_HBS;
            state_nxt = S_ENG;
          end
        end
        PH_HBS: begin
          if (eng_pass) begin
            cmd.op    = OP_ENG_HBR;
            phase_nxt = PH_HBR;
            state_nxt = S_ENG;
          end else begin
            cmd.op    = OP_ZINC;
            state_nxt = S_HA;
          end
        end
        PH_HBR: begin
          cmd.op    = eng_pass ? OP_JMP_HB : OP_ZINC;
          state_nxt = eng_pass ? S_LOOP : S_HA;
        end
        PH_TA: begin
          cmd.op    = eng_pass ? OP_USED_INC : OP_NONE;
          state_nxt = eng_pass ? S_DONE : S_T2;
        end
        PH_TF: begin
          cmd.op    = eng_pass ? OP_USED_INC : OP_FAIL;
          state_nxt = S_DONE;
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_MM;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_engc_from_eng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENGC) |-> $past(state_r == S_ENG))
    else $error("compare state entered without a read");
  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_busy) |=> (state_r == S_IDLE))
    else $error("finished item not released");
  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && in_mode == MODE_START) |=> (state_r == S_LOOP))
    else $error("start item did not begin the walk");
`endif

endmodule

[hdl/bdsa_dp.sv]
// Datapath of the aligner: sequence memories, lengths, walk indices, compare engine,
// configuration and the output register. Depends on bdsa_pkg; commanded by bdsa_ctrl.
module bdsa_dp #(
  parameter int MAX_SEQ_LEN = bdsa_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bdsa_pkg::cmd_t cmd,
  output bdsa_pkg::sts_t sts,
  input  logic [1:0]     in_mode,
  input  logic [23:0]    in_tdata,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [4:0]     cfg_wdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata
);
  import bdsa_pkg::*;

  localparam int AW = $clog2(MAX_SEQ_LEN);
  localparam int LW = AW + 1;
  localparam int XW = LW + 1;
  localparam int SW = XW + 2;
  localparam int KW = (LW > 6) ? LW : 6;
  localparam int PW = ((XW > KW) ? XW : KW) + 1;
  localparam int CW = ((LW > 10) ? LW : 10) + 2;

  typedef enum logic [1:0] {K_PAIR, K_SAME_A, K_SAME_B} kind_t;

  logic [1:0]    mem_a [MAX_SEQ_LEN];
  logic [1:0]    mem_b [MAX_SEQ_LEN];
  logic [1:0]    ra_r, rb_r;
  logic [LW-1:0] len_a_r, len_b_r;
  logic [3:0]    bud_r;
  logic [4:0]    anc_r;
  logic [XW-1:0] i_r, j_r, pa_r, pb_r;
  logic [4:0]    z_r, used_r, start_r;
  logic [KW-1:0] k_r, lim_r;
  kind_t         kind_r;
  logic          ok_r, out_valid_r;
  logic [1:0]    last_r, ai_r, bj_r, c_r;
  logic [9:0]    pcl_r, out_cl_r;
  logic [4:0]    out_dc_r;
  logic          out_ok_r;

  logic [1:0]          in_base, in_prev;
  logic [9:0]          in_pcl;
  logic [3:0]          in_pdc;
  logic                in_pok;
  logic [PW-1:0]       eng_a, eng_b;
  logic [XW-1:0]       im1;
  logic [AW-1:0]       raddr_a, raddr_b;
  logic                wr_a, wr_b;
  logic signed [5:0]   rem6;
  logic signed [SW-1:0] i_s, j_s, lim1_s, lim2_s;
  logic [LW-1:0]       min_len;
  logic signed [CW-1:0] cl_s;
  logic [9:0]          cl_v;
  logic [KW-1:0]       zp1;
  logic [XW-1:0]       jump_full, jump_st;

  assign in_base   = in_tdata[1:0];
  assign in_prev   = in_tdata[3:2];
  assign in_pcl    = in_tdata[13:4];
  assign in_pdc    = in_tdata[17:14];
  assign in_pok    = in_tdata[18];

  assign eng_a = PW'(pa_r) + PW'(k_r);
  assign eng_b = PW'(pb_r) + PW'(k_r);
  assign im1   = i_r - XW'(1);
  assign zp1   = KW'(z_r) + KW'(1);
  assign jump_st   = XW'(anc_r);
  assign jump_full = XW'(anc_r) + XW'(z_r) + XW'(1);

  always_comb begin
    case (cmd.op)
      OP_RD_IJ: begin
        raddr_a = i_r[AW-1:0];
        raddr_b = j_r[AW-1:0];
      end
      OP_MISS: begin
        raddr_a = im1[AW-1:0];
        raddr_b = j_r[AW-1:0];
      end
      default: begin
        raddr_a = eng_a[AW-1:0];
        raddr_b = eng_b[AW-1:0];
      end
    endcase
  end

  assign wr_a = (cmd.op == OP_LOAD) && (in_mode == MODE_LOAD_A)
                && (len_a_r < LW'(MAX_SEQ_LEN));
  assign wr_b = (cmd.op == OP_LOAD) && (in_mode == MODE_LOAD_B)
                && (len_b_r < LW'(MAX_SEQ_LEN));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[len_a_r[AW-1:0]] <= in_base;
    end
    ra_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[len_b_r[AW-1:0]] <= in_base;
    end
    rb_r <= mem_b[raddr_b];
  end

  assign rem6   = $signed({2'b00, bud_r}) - $signed({1'b0, used_r});
  assign i_s    = $signed({2'b00, i_r});
  assign j_s    = $signed({2'b00, j_r});
  assign lim1_s = $signed({{(SW-LW){1'b0}}, len_a_r}) - $signed({{(SW-5){1'b0}}, anc_r})
                  - $signed({{(SW-6){rem6[5]}}, rem6});
  assign lim2_s = $signed({{(SW-LW){1'b0}}, len_b_r}) - $signed({{(SW-5){1'b0}}, anc_r})
                  - $signed({{(SW-6){rem6[5]}}, rem6});

  always_comb begin
    sts.loop_go  = (i_r < XW'(len_a_r)) && (j_r < XW'(len_b_r));
    sts.eq       = (ra_r == rb_r);
    sts.guard    = (i_s < lim1_s) && (j_s < lim2_s);
    sts.z_lt_rem = ($signed({1'b0, z_r}) < rem6);
    sts.eng_stop = (k_r >= lim_r) || ((kind_r == K_PAIR)
                   && ((eng_a >= PW'(len_a_r)) || (eng_b >= PW'(len_b_r))));
    case (kind_r)
      K_SAME_A: sts.eng_eq = (ra_r == c_r);
      K_SAME_B: sts.eng_eq = (rb_r == c_r);
      default:  sts.eng_eq = (ra_r == rb_r);
    endcase
    sts.c_eq_a   = (c_r == ai_r);
    sts.c_eq_b   = (c_r == bj_r);
    sts.out_busy = out_valid_r && !out_tready;
  end

  assign min_len = (len_a_r <= len_b_r) ? len_a_r : len_b_r;
  assign cl_s    = $signed(CW'(pcl_r)) + $signed(CW'(min_len))
                   - $signed(CW'(used_r - start_r));

  always_comb begin
    if (cl_s < 0) begin
      cl_v = '0;
    end else if (cl_s > $signed(CW'(CL_MAX))) begin
      cl_v = CL_MAX;
    end else begin
      cl_v = cl_s[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r     <= '0;
      len_b_r     <= '0;
      bud_r       <= '0;
      anc_r       <= ANCHOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIFF_BUDGET: bud_r <= cfg_wdata[3:0];
          CFG_ANCHOR_LEN:  anc_r <= cfg_wdata;
          default:         bud_r <= bud_r;
        endcase
      end
      if (wr_a) begin
        len_a_r <= len_a_r + LW'(1);
      end
      if (wr_b) begin
        len_b_r <= len_b_r + LW'(1);
      end
      if (cmd.op == OP_FIN) begin
        len_a_r     <= '0;
        len_b_r     <= '0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        last_r  <= in_prev;
        pcl_r   <= in_pcl;
        used_r  <= {1'b0, in_pdc};
        start_r <= {1'b0, in_pdc};
        ok_r    <= in_pok;
        i_r     <= '0;
        j_r     <= '0;
      end
      OP_STEP: begin
        i_r <= i_r + XW'(1);
        j_r <= j_r + XW'(1);
      end
      OP_MISS: begin
        ai_r <= ra_r;
        bj_r <= rb_r;
      end
      OP_PREV:  c_r <= (i_r == '0) ? last_r : ra_r;
      OP_Z0:    z_r <= '0;
      OP_ZINC:  z_r <= z_r + 5'd1;
      OP_ENG_MM: begin
        pa_r <= i_r + XW'(z_r) + XW'(1);
        pb_r <= j_r + XW'(z_r) + XW'(1);
        lim_r <= KW'(anc_r);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_HAS: begin
        pa_r <= i_r;
        lim_r <= zp1;
        kind_r <= K_SAME_A;
        k_r <= '0;
      end
      OP_ENG_HAR: begin
        pa_r <= i_r + XW'(z_r) + XW'(1);
        pb_r <= j_r;
        lim_r <= KW'(anc_r);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_HBS: begin
        pb_r <= j_r;
        lim_r <= zp1;
        kind_r <= K_SAME_B;
        k_r <= '0;
      end
      OP_ENG_HBR: begin
        pa_r <= i_r;
        pb_r <= j_r + XW'(z_r) + XW'(1);
        lim_r <= KW'(anc_r);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_T1: begin
        pa_r <= i_r + XW'(1);
        pb_r <= j_r + XW'(1);
        lim_r <= KW'(MAX_SEQ_LEN);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_T2A: begin
        pa_r <= i_r + XW'(1);
        pb_r <= j_r;
        lim_r <= KW'(MAX_SEQ_LEN);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_T2B: begin
        pa_r <= i_r;
        pb_r <= j_r + XW'(1);
        lim_r <= KW'(MAX_SEQ_LEN);
        kind_r <= K_PAIR;
        k_r <= '0;
      end
      OP_ENG_NEXT: k_r <= k_r + KW'(1);
      OP_JMP_MM: begin
        i_r <= i_r + jump_full;
        j_r <= j_r + jump_full;
        used_r <= used_r + z_r + 5'd1;
      end
      OP_JMP_HA: begin
        i_r <= i_r + jump_full;
        j_r <= j_r + jump_st;
        used_r <= used_r + z_r + 5'd1;
      end
      OP_JMP_HB: begin
        i_r <= i_r + jump_st;
        j_r <= j_r + jump_full;
        used_r <= used_r + z_r + 5'd1;
      end
      OP_USED_INC: used_r <= used_r + 5'd1;
      OP_FAIL:     ok_r <= 1'b0;
      OP_FIN: begin
        out_cl_r <= cl_v;
        out_dc_r <= used_r;
        out_ok_r <= ok_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ok_r, out_dc_r, out_cl_r};

`ifndef ASSERT_OFF
  a_len_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_a_r <= LW'(MAX_SEQ_LEN))
    else $error("first length beyond store depth");
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) |=> (len_a_r == '0 && len_b_r == '0 && out_valid_r))
    else $error("finish did not clear lengths or post the result");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while still pending");
`endif

endmodule

[test/bounded_difference_sequence_aligner_top_tb.sv]
// Self-checking testbench for the bounded difference sequence aligner top level.
// Loads random and edited sequence pairs, predicts each alignment result in a scoreboard
// class and compares every output item; depends on bdsa_pkg and the top level RTL.
module bounded_difference_sequence_aligner_top_tb;
  import bdsa_pkg::*;

  class aligner_scoreboard;
    logic [1:0] first_bases[256];
    logic [1:0] second_bases[256];
    int first_len, second_len;
    int budget, anchor;
    logic [15:0] expected_results[$];
    int errors;

    function new();
      first_len = 0;
      second_len = 0;
      budget = 0;
      anchor = int'(ANCHOR_RESET);
      errors = 0;
    endfunction

    function int base_of(bit second, int idx);
      if (idx < 0 || idx >= 256) return 0;
      return second ? int'(second_bases[idx]) : int'(first_bases[idx]);
    endfunction

    function bit runs_match(int ia, int ib, int n);
      for (int k = 0; k < n; k++)
        if (base_of(0, ia + k) != base_of(1, ib + k)) return 0;
      return 1;
    endfunction

    function bit all_same(bit second, int from, int count, int c);
      for (int y = 0; y < count; y++)
        if (base_of(second, from + y) != c) return 0;
      return 1;
    endfunction

    function void note_input(logic [1:0] mode, logic [23:0] d);
      int i, j, z, zf, c, rem, used, start_used, ok, last, n1, n2, st;
      bit found, done, all;
      int cl;
      if (mode == MODE_LOAD_A) begin
        if (first_len < 256) first_bases[first_len++] = d[1:0];
        return;
      end
      if (mode == MODE_LOAD_B) begin
        if (second_len < 256) second_bases[second_len++] = d[1:0];
        return;
      end
      if (mode != MODE_START) return;
      n1 = first_len;
      n2 = second_len;
      st = anchor;
      used = int'(d[17:14]);
      start_used = used;
      ok = int'(d[18]);
      last = int'(d[3:2]);
      i = 0;
      j = 0;
      done = 0;
      while (!done && i < n1 && j < n2) begin
        if (first_bases[i] == second_bases[j]) begin
          i++;
          j++;
        end else begin
          c = (i == 0) ? last : base_of(0, i - 1);
          rem = budget - used;
          if (i < n1 - st - rem && j < n2 - st - rem) begin
            found = 0;
            zf = 0;
            for (z = 0; z < rem && !found; z++)
              if (runs_match(i + z + 1, j + z + 1, st)) begin
                i += st + z;
                j += st + z;
                found = 1;
                zf = z;
              end
            if (!found) begin
              for (z = 0; z < rem && !found; z++) begin
                if (all_same(0, i, z + 1, c) && runs_match(i + z + 1, j, st)) begin
                  i += z + st;
                  j += st - 1;
                  found = 1;
                  zf = z;
                end else if (all_same(1, j, z + 1, c) && runs_match(i, j + z + 1, st)) begin
                  i += st - 1;
                  j += z + st;
                  found = 1;
                  zf = z;
                end
              end
            end
            if (found) begin
              used += zf + 1;
              i++;
              j++;
            end else begin
              ok = 0;
              done = 1;
            end
          end else begin
            all = 1;
            for (z = 1; z < n1 - i && z < n2 - j && all; z++)
              if (first_bases[i + z] != second_bases[j + z]) all = 0;
            if (all) begin
              used += 1;
            end else begin
              found = 0;
              if (c == int'(first_bases[i])) begin
                found = 1;
                for (z = 0; z < n1 - i - 1 && z < n2 - j && found; z++)
                  if (first_bases[i + 1 + z] != second_bases[j + z]) found = 0;
              end else if (c == int'(second_bases[j])) begin
                found = 1;
                for (z = 0; z < n1 - i && z < n2 - j - 1 && found; z++)
                  if (first_bases[i + z] != second_bases[j + 1 + z]) found = 0;
              end
              if (found) used += 1;
              else ok = 0;
            end
            done = 1;
          end
        end
      end
      cl = int'(d[13:4]) + ((n1 <= n2) ? n1 : n2) - (used - start_used);
      if (cl < 0) cl = 0;
      if (cl > 1023) cl = 1023;
      if (used > 31) used = 31;
      if (used < 0) used = 0;
      expected_results.push_back({ok[0], used[4:0], cl[9:0]});
      first_len = 0;
      second_len = 0;
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (expected_results.size() == 0) begin
        $error("unexpected output item %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got[9:0] !== want[9:0]) begin
        $error("consistent_len expected %0d actual %0d", want[9:0], got[9:0]);
        errors++;
      end
      if (got[14:10] !== want[14:10]) begin
        $error("diff_count expected %0d actual %0d", want[14:10], got[14:10]);
        errors++;
      end
      if (got[15] !== want[15]) begin
        $error("overlap_ok expected %0d actual %0d", want[15], got[15]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = MODE_NOP;
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;
  logic cfg_we = 0;
  logic cfg_index = CFG_DIFF_BUDGET;
  logic [4:0] cfg_wdata = '0;

  aligner_scoreboard board = new();
  int cycles = 0;
  int items_sent = 0;
  bit no_idle = 0;
  int out_hold = 0;

  bounded_difference_sequence_aligner_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("bounded_difference_sequence_aligner_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 0;
      out_hold--;
    end else begin
      out_tready <= 1;
      if ($urandom_range(0, 3) == 0) out_hold = gap_len();
    end
  end

  task automatic send_item(logic [1:0] mode, logic [23:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic start_item(int prev, int pcl, int pdc, int pok);
    logic [23:0] d;
    d = '0;
    d[1:0] = 2'($urandom_range(0, 3));
    d[3:2] = 2'(prev);
    d[13:4] = 10'(pcl);
    d[17:14] = 4'(pdc);
    d[18] = pok[0];
    send_item(MODE_START, d);
  endtask

  task automatic write_reg(logic idx, int value);
    in_tvalid <= 0;
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 5'(value);
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_DIFF_BUDGET) board.budget = value & 15;
    else board.anchor = value & 31;
  endtask

  // Loads a random first sequence and an edited copy as the second, then starts.
  task automatic aligned_pair(int len, int edits, bit random_priors);
    logic [1:0] a[$];
    logic [1:0] b[$];
    int k, r, prev;
    for (k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 2) == 0) a.push_back(a[k - 1]);
      else a.push_back(2'($urandom_range(0, 3)));
    end
    for (k = 0; k < len; k++) begin
      r = (edits > 0 && $urandom_range(0, len) < edits) ? $urandom_range(1, 4) : 0;
      case (r)
        1: b.push_back(a[k] + 2'd1);
        2: ;
        3: begin
          b.push_back(a[k]);
          b.push_back(a[k]);
        end
        4: begin
          b.push_back(2'($urandom_range(0, 3)));
          b.push_back(a[k]);
        end
        default: b.push_back(a[k]);
      endcase
    end
    if ($urandom_range(0, 9) == 0) b.push_back(2'($urandom_range(0, 3)));
    for (k = 0; k < a.size(); k++) send_item(MODE_LOAD_A, {22'd0, a[k]});
    for (k = 0; k < b.size(); k++) send_item(MODE_LOAD_B, {22'd0, b[k]});
    if ($urandom_range(0, 9) == 0) send_item(MODE_NOP, 24'($urandom()));
    prev = (len > 0 && $urandom_range(0, 1)) ? int'(a[0]) : $urandom_range(0, 3);
    if (random_priors)
      start_item(prev, $urandom_range(0, 1023),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                 $urandom_range(0, 3) != 0);
    else
      start_item(prev, 0, 0, 1);
  endtask

  task automatic noise_item();
    send_item(2'($urandom_range(0, 3)), {5'd0, 19'($urandom())});
  endtask

  initial begin
    int phase, len, k;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part at the reset settings, at the largest budget and at anchor lengths 0 and 16.
    aligned_pair(8, 0, 0);
    aligned_pair(12, 3, 0);
    send_item(MODE_NOP, 24'hffffff);
    start_item(3, 1023, 15, 1);
    start_item(0, 0, 0, 0);
    write_reg(CFG_DIFF_BUDGET, 15);
    write_reg(CFG_ANCHOR_LEN, 0);
    aligned_pair(16, 4, 1);
    start_item(1, 1023, 15, 1);
    write_reg(CFG_ANCHOR_LEN, 16);
    aligned_pair(40, 3, 1);
    // A full first store ignores further loads.
    for (k = 0; k < 258; k++) send_item(MODE_LOAD_A, {22'd0, 2'(k % 3)});
    for (k = 0; k < 250; k++) send_item(MODE_LOAD_B, {22'd0, 2'(k % 3)});
    start_item(2, 1000, 2, 1);

    phase = 0;
    while (items_sent < 1850) begin
      if (items_sent > 600 * ((phase + 1) / 2) || phase == 0) begin
        write_reg(CFG_DIFF_BUDGET, (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 15 :
                  $urandom_range(0, 15));
        write_reg(CFG_ANCHOR_LEN, (phase % 4 == 0) ? 1 : (phase % 4 == 1) ? 16 :
                  $urandom_range(0, 16));
        no_idle = (phase % 3 == 2);
        phase++;
      end
      k = $urandom_range(0, 9);
      if (k < 8) begin
        len = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 256) : $urandom_range(0, 24);
        aligned_pair(len, $urandom_range(0, 4), 1);
      end else begin
        repeat ($urandom_range(1, 6)) noise_item();
      end
    end
    in_tvalid <= 0;
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("bounded_difference_sequence_aligner_top_tb: clean");
    else
      $display("bounded_difference_sequence_aligner_top_tb: errors");
    $finish;
  end
endmodule

[files.f]
hdl/bdsa_pkg.sv
hdl/bdsa_ctrl.sv
hdl/bdsa_dp.sv
hdl/bounded_difference_sequence_aligner_top.sv
test/bounded_difference_sequence_aligner_top_tb.sv
